// ===== rtl/osa_pkg.sv =====
package osa_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int USER_BITS_DEF = 8;
    localparam int RUN_LIMIT     = 64;

    localparam int CFG_W   = 7;
    localparam int WHO_W   = 8;
    localparam int IDX_W   = 6;
    localparam int OWNER_W = 8;
    localparam int KIND_W  = 2;

    localparam logic [CFG_W-1:0] SLOTS_RST = 7'd64;
    localparam logic [1:0]       REG_SLOTS_ADDR = 2'd0;

    typedef enum logic [KIND_W-1:0] {
        K_VIEW        = 2'd0,
        K_ALLOC_FIRST = 2'd1,
        K_ALLOC_GIVEN = 2'd2,
        K_RELEASE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/owner_tagged_slot_allocator_unit.sv =====
// Channel  | Dir | Transfer when           | Payload
// ---------+-----+------------------------+------------------------------------------
// s stream | in  | i_s_tvalid & o_s_tready | tuser: kind; tdata: user_id, slot_index
// m stream | out | o_m_tvalid & i_m_tready | tuser: op_code; tlast: last;
//          |     |                         | tdata: requester .. slot_owner
// APB cfg  | in  | psel&penable&pwrite     | slots_in_use at byte address 0
//
// Each request goes through acceptance in the idle state, one full rotation of the cell
// chain (the head cell checked and rewritten on its way back to the tail), and the
// finish state that loads the result. A view stalls the rotation at each reported slot
// while the output register is full; any other result waits in the finish state instead.
// Reset is synchronous: all slots free, no owners, slots_in_use = 64.
// A new request is taken while a finished result still sits in the output register.
module owner_tagged_slot_allocator_unit import osa_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int USER_BITS = USER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] user_id, [13:8] slot_index, [15:14] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] requester, [8] success, [9] slot_valid,
                                     // [15:10] result_slot, [23:16] slot_owner
    output logic [1:0]  o_m_tuser,   // [1:0] op_code
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0]     r_slots;
    logic                 shift, wr_res, head_res;
    logic [USER_BITS-1:0] wr_own, head_own;
    logic                 chain_res [SLOTS+1];
    logic [USER_BITS-1:0] chain_own [SLOTS+1];
    t_kind                op;
    logic                 ok, slot_valid;
    logic [IDX_W-1:0]     slot;
    logic [OWNER_W-1:0]   owner;
    logic [WHO_W-1:0]     who;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SLOTS_ADDR) ? {{(32 - CFG_W){1'b0}}, r_slots} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_RST;
        end else if (psel && penable && pwrite && pready && paddr == REG_SLOTS_ADDR) begin
            r_slots <= pwdata[CFG_W-1:0];
        end
    end

    // cell k takes from cell k+1; the tail takes the rewritten head
    assign chain_res[SLOTS] = wr_res;
    assign chain_own[SLOTS] = wr_own;

    for (genvar gk = 0; gk < SLOTS; gk++) begin : g_cell
        osa_cell #(
            .USER_BITS(USER_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_res   (chain_res[gk+1]),
            .i_own   (chain_own[gk+1]),
            .o_res   (chain_res[gk]),
            .o_own   (chain_own[gk])
        );
    end

    assign head_res = chain_res[0];
    assign head_own = chain_own[0];

    osa_ctrl #(
        .SLOTS     (SLOTS),
        .USER_BITS (USER_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slots      (r_slots),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_kind       (t_kind'(i_s_tuser)),
        .i_who        (i_s_tdata[7:0]),
        .i_idx        (i_s_tdata[13:8]),
        .i_head_res   (head_res),
        .i_head_own   (head_own),
        .o_shift      (shift),
        .o_wr_res     (wr_res),
        .o_wr_own     (wr_own),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_op         (op),
        .o_who        (who),
        .o_ok         (ok),
        .o_slot_valid (slot_valid),
        .o_slot       (slot),
        .o_owner      (owner),
        .o_last       (o_m_tlast)
    );

    assign o_m_tuser = op;
    assign o_m_tdata = {owner, slot, slot_valid, ok, who};

endmodule

// ===== rtl/osa_cell.sv =====
module osa_cell import osa_pkg::*; #(
    parameter int USER_BITS = USER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_res,
    input  logic [USER_BITS-1:0] i_own,
    output logic                 o_res,
    output logic [USER_BITS-1:0] o_own
);

    logic                 r_res;
    logic [USER_BITS-1:0] r_own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 1'b0;
            r_own <= '0;
        end else if (i_shift) begin
            r_res <= i_res;
            r_own <= i_own;
        end
    end

    assign o_res = r_res;
    assign o_own = r_own;

endmodule

// ===== rtl/osa_ctrl.sv =====
module osa_ctrl import osa_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int USER_BITS = USER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CFG_W-1:0]     i_slots,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_kind                i_kind,
    input  logic [WHO_W-1:0]     i_who,
    input  logic [IDX_W-1:0]     i_idx,
    // head of the cell chain
    input  logic                 i_head_res,
    input  logic [USER_BITS-1:0] i_head_own,
    output logic                 o_shift,
    output logic                 o_wr_res,
    output logic [USER_BITS-1:0] o_wr_own,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_kind                o_op,
    output logic [WHO_W-1:0]     o_who,
    output logic                 o_ok,
    output logic                 o_slot_valid,
    output logic [IDX_W-1:0]     o_slot,
    output logic [OWNER_W-1:0]   o_owner,
    output logic                 o_last
);

    localparam int PW = $clog2(SLOTS);
    localparam int NW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

    t_state               r_state, n_state;
    logic [PW-1:0]        r_pos, n_pos;
    t_kind                r_kind, n_kind;
    logic [WHO_W-1:0]     r_who, n_who;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_ok, n_ok;
    logic                 r_valid, n_valid;
    logic [IDX_W-1:0]     r_rslot, n_rslot;
    logic [OWNER_W-1:0]   r_rowner, n_rowner;

    logic                 r_ovalid, n_ovalid;
    t_kind                r_o_op, n_o_op;
    logic [WHO_W-1:0]     r_o_who, n_o_who;
    logic                 r_o_ok, n_o_ok;
    logic                 r_o_valid, n_o_valid;
    logic [IDX_W-1:0]     r_o_slot, n_o_slot;
    logic [OWNER_W-1:0]   r_o_owner, n_o_owner;
    logic                 r_o_last, n_o_last;

    logic [USER_BITS-1:0] uid;
    logic [OWNER_W-1:0]   uid8, head8;
    logic [NW-1:0]        pos_x, idx_x, slots_x, n_act, runs;
    logic                 out_free, hit, in_view, in_fire;

    // user id kept to USER_BITS; owners shown on 8 bits
    for (genvar gb = 0; gb < USER_BITS; gb++) begin : g_uid
        if (gb < WHO_W) begin : g_in
            assign uid[gb] = r_who[gb];
        end else begin : g_zero
            assign uid[gb] = 1'b0;
        end
    end
    for (genvar gb = 0; gb < OWNER_W; gb++) begin : g_own8
        if (gb < USER_BITS) begin : g_in
            assign uid8[gb]  = uid[gb];
            assign head8[gb] = i_head_own[gb];
        end else begin : g_zero
            assign uid8[gb]  = 1'b0;
            assign head8[gb] = 1'b0;
        end
    end

    assign pos_x   = NW'(r_pos);
    assign idx_x   = NW'(r_idx);
    assign slots_x = NW'(i_slots);
    assign n_act   = (slots_x > NW'(SLOTS)) ? NW'(SLOTS) : slots_x;
    assign runs    = (n_act > NW'(RUN_LIMIT)) ? NW'(RUN_LIMIT) : n_act;
    assign hit     = (pos_x == idx_x) && (idx_x < n_act);
    assign in_view = (pos_x < runs);

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_who     = r_who;
        n_idx     = r_idx;
        n_ok      = r_ok;
        n_valid   = r_valid;
        n_rslot   = r_rslot;
        n_rowner  = r_rowner;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_o_op    = r_o_op;
        n_o_who   = r_o_who;
        n_o_ok    = r_o_ok;
        n_o_valid = r_o_valid;
        n_o_slot  = r_o_slot;
        n_o_owner = r_o_owner;
        n_o_last  = r_o_last;
        o_shift   = 1'b0;
        o_wr_res  = i_head_res;
        o_wr_own  = i_head_own;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state  = ST_SCAN;
                    n_pos    = '0;
                    n_kind   = i_kind;
                    n_who    = i_who;
                    n_idx    = i_idx;
                    n_ok     = 1'b0;
                    n_valid  = 1'b0;
                    n_rslot  = '0;
                    n_rowner = '0;
                end
            end
            ST_SCAN: begin
                // view waits at each reported slot until the output register frees up
                if (!(r_kind == K_VIEW && in_view) || out_free) begin
                    o_shift = 1'b1;
                    n_pos   = r_pos + 1'b1;
                    if (r_pos == PW'(SLOTS - 1)) begin
                        n_state = ST_FINISH;
                    end
                    case (r_kind)
                        K_VIEW: begin
                            if (in_view) begin
                                n_ovalid  = 1'b1;
                                n_o_op    = r_kind;
                                n_o_who   = r_who;
                                n_o_ok    = 1'b1;
                                n_o_valid = 1'b1;
                                n_o_slot  = pos_x[IDX_W-1:0];
                                n_o_owner = i_head_res ? head8 : '0;
                                n_o_last  = (pos_x == runs - 1'b1);
                            end
                        end
                        K_ALLOC_FIRST: begin
                            if (!r_ok && (pos_x < n_act) && !i_head_res) begin
                                o_wr_res = 1'b1;
                                o_wr_own = uid;
                                n_ok     = 1'b1;
                                n_valid  = 1'b1;
                                n_rslot  = pos_x[IDX_W-1:0];
                                n_rowner = uid8;
                            end
                        end
                        K_ALLOC_GIVEN: begin
                            if (hit && !i_head_res) begin
                                o_wr_res = 1'b1;
                                o_wr_own = uid;
                                n_ok     = 1'b1;
                                n_valid  = 1'b1;
                                n_rslot  = r_idx;
                                n_rowner = uid8;
                            end
                        end
                        K_RELEASE: begin
                            if (hit) begin
                                n_valid = 1'b1;
                                n_rslot = r_idx;
                                if (i_head_res && (i_head_own == uid)) begin
                                    o_wr_res = 1'b0;
                                    o_wr_own = '0;
                                    n_ok     = 1'b1;
                                    n_rowner = '0;
                                end else begin
                                    n_rowner = i_head_res ? head8 : '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FINISH: begin
                if (r_kind == K_VIEW && n_act != '0) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_state   = ST_IDLE;
                    n_ovalid  = 1'b1;
                    n_o_op    = r_kind;
                    n_o_who   = r_who;
                    n_o_ok    = (r_kind == K_VIEW) ? 1'b1 : r_ok;
                    n_o_valid = r_valid;
                    n_o_slot  = r_valid ? r_rslot : '0;
                    n_o_owner = r_valid ? r_rowner : '0;
                    n_o_last  = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_who     <= n_who;
        r_idx     <= n_idx;
        r_ok      <= n_ok;
        r_valid   <= n_valid;
        r_rslot   <= n_rslot;
        r_rowner  <= n_rowner;
        r_o_op    <= n_o_op;
        r_o_who   <= n_o_who;
        r_o_ok    <= n_o_ok;
        r_o_valid <= n_o_valid;
        r_o_slot  <= n_o_slot;
        r_o_owner <= n_o_owner;
        r_o_last  <= n_o_last;
    end

    assign o_out_valid  = r_ovalid;
    assign o_op         = r_o_op;
    assign o_who        = r_o_who;
    assign o_ok         = r_o_ok;
    assign o_slot_valid = r_o_valid;
    assign o_slot       = r_o_slot;
    assign o_owner      = r_o_owner;
    assign o_last       = r_o_last;

endmodule
